// File: hw/rtl/lidar_point_sector_binner_top_assert.svh
// assertion macros for the lidar point sector binner
`ifndef LIDAR_POINT_SECTOR_BINNER_TOP_ASSERT_SVH
`define LIDAR_POINT_SECTOR_BINNER_TOP_ASSERT_SVH

// same-cycle implication
`define LPSB_ASSERT_IMP(name, clk, rst, ante, cons, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define LPSB_ASSERT_NXT(name, clk, rst, ante, cons, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

// implication after a fixed number of cycles
`define LPSB_ASSERT_DLY(name, clk, rst, ante, dly, cons, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> ##dly (cons)) \
      else $error(msg);

`endif

// File: hw/rtl/lpsb_pkg.sv
// shared types, constants and tables for the lidar point sector binner
`timescale 1ns / 1ps

package lpsb_pkg;

   localparam int LAYERS_DEFAULT = 5;
   localparam int LAYERS_MAX     = 5;
   localparam int LAYER_W        = 3;
   localparam int INDEX_W        = 6;

   localparam int COORD_W     = 20;
   localparam int XMAG_W      = COORD_W - 1;
   localparam int INTENSITY_W = 8;
   localparam int BOUND_W     = 16;
   localparam int CSR_ADDR_W  = 3;
   localparam int CSR_DATA_W  = 16;
   localparam int BOUNDS_MAX  = LAYERS_MAX - 1;

   // cordic datapath
   localparam int CW           = COORD_W + 3;
   localparam int ANG_W        = 18;
   localparam int CORDIC_STEPS = 14;
   localparam logic [13:0] CORDIC_TAB [CORDIC_STEPS] = '{
      14'd8192, 14'd4836, 14'd2555, 14'd1297, 14'd651, 14'd326, 14'd163,
      14'd81, 14'd41, 14'd20, 14'd10, 14'd5, 14'd3, 14'd1
   };
   localparam logic signed [ANG_W-1:0] HALF_TURN = 18'sd32768;

   // ring layer products
   localparam int R2_W  = 2 * COORD_W;
   localparam int P_W   = BOUND_W + XMAG_W;
   localparam int PL_W  = P_W / 2;
   localparam int PH_W  = P_W - PL_W;
   localparam int SQ_W  = 2 * P_W;
   localparam int TAN_FRAC2 = 28;

   // sector quantizer
   localparam int U_W    = 17;
   localparam int SECT_W = 7;
   localparam int TMP_W  = U_W + 6;
   localparam logic [U_W-1:0] U_FULL = 17'd65536;
   localparam logic [TMP_W-1:0] SECT_ROUND = 23'd65535;

   localparam logic signed [COORD_W-1:0] NEAR_LIMIT = 20'sd100;

   localparam logic [INTENSITY_W-1:0] INTENSITY_LOW_RESET  = 8'd120;
   localparam logic [INTENSITY_W-1:0] INTENSITY_HIGH_RESET = 8'd175;
   localparam logic [BOUND_W-1:0] BOUND_RESET [BOUNDS_MAX] = '{
      16'd2023, 16'd4109, 16'd6329, 16'd8769
   };

   typedef enum logic [CSR_ADDR_W-1:0] {
      CSR_INTENSITY_LOW  = 3'd0,
      CSR_INTENSITY_HIGH = 3'd1,
      CSR_TAN_FIRST      = 3'd2,
      CSR_TAN_SECOND     = 3'd3,
      CSR_TAN_THIRD      = 3'd4,
      CSR_TAN_FOURTH     = 3'd5
   } lpsb_csr_type;

   typedef struct packed {
      logic signed [CW-1:0]    y;
      logic signed [CW-1:0]    z;
      logic signed [ANG_W-1:0] ang;
   } lpsb_vec_type;

   typedef struct packed {
      logic valid;
      logic near;
      logic keep;
   } lpsb_tag_type;

   typedef struct packed {
      logic neg;
      logic zero;
   } lpsb_xflag_type;

   // log2 of the sector count of a layer
   function automatic logic [2:0] lpsb_sector_shift(input logic [LAYER_W-1:0] layer);
      logic [2:0] s;
      unique case (layer)
         3'd0:    s = 3'd0;
         3'd1:    s = 3'd2;
         3'd2:    s = 3'd3;
         3'd3:    s = 3'd4;
         3'd4:    s = 3'd5;
         default: s = 3'd0;
      endcase
      return s;
   endfunction

   function automatic logic [INDEX_W-1:0] lpsb_layer_base(input logic [LAYER_W-1:0] layer);
      logic [INDEX_W-1:0] b;
      unique case (layer)
         3'd0:    b = 6'd0;
         3'd1:    b = 6'd1;
         3'd2:    b = 6'd5;
         3'd3:    b = 6'd13;
         3'd4:    b = 6'd29;
         default: b = 6'd0;
      endcase
      return b;
   endfunction

endpackage

// File: hw/rtl/lpsb_cordic_cell.sv
// one vectoring step of the atan2 cell chain
`timescale 1ns / 1ps

module lpsb_cordic_cell import lpsb_pkg::*; #(
   parameter int STEP = 0
) (
   input  logic         clock,
   input  logic         reset,
   input  lpsb_vec_type vec_in,
   input  lpsb_tag_type tag_in,
   output lpsb_vec_type vec_out,
   output lpsb_tag_type tag_out
);

   localparam logic signed [ANG_W-1:0] STEP_ANGLE = ANG_W'(CORDIC_TAB[STEP]);

   logic signed [CW-1:0]    y_cur;
   logic signed [CW-1:0]    z_cur;
   logic signed [CW-1:0]    dz;
   logic signed [CW-1:0]    dy;
   logic signed [ANG_W-1:0] ang_cur;
   lpsb_vec_type            vec_ff;
   lpsb_vec_type            vec_nx_in;
   lpsb_tag_type            tag_ff;

   always_comb begin
      y_cur   = vec_in.y;
      z_cur   = vec_in.z;
      ang_cur = vec_in.ang;
      dz      = y_cur >>> STEP;
      dy      = z_cur >>> STEP;
      if (!y_cur[CW-1]) begin
         vec_nx_in.z   = z_cur + dz;
         vec_nx_in.y   = y_cur - dy;
         vec_nx_in.ang = ang_cur + STEP_ANGLE;
      end else begin
         vec_nx_in.z   = z_cur - dz;
         vec_nx_in.y   = y_cur + dy;
         vec_nx_in.ang = ang_cur - STEP_ANGLE;
      end
   end

   always_ff @(posedge clock) begin
      vec_ff <= vec_nx_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tag_ff <= '0;
      end else begin
         tag_ff <= tag_in;
      end
   end

   assign vec_out = vec_ff;
   assign tag_out = tag_ff;

endmodule

// File: hw/rtl/lpsb_bound_cell.sv
// squared tangent test of one ring bound, four stages
`timescale 1ns / 1ps

module lpsb_bound_cell import lpsb_pkg::*; (
   input  logic               clock,
   input  logic [XMAG_W-1:0]  x_mag,
   input  logic [BOUND_W-1:0] bound,
   input  logic [R2_W-1:0]    r2_late,
   output logic               hit
);

   logic [P_W-1:0]        prod_ff;
   logic [P_W-1:0]        prod_in;
   logic [PH_W-1:0]       ph;
   logic [PL_W-1:0]       pl;
   logic [2*PH_W-1:0]     hh_ff;
   logic [2*PH_W-1:0]     hh_in;
   logic [PH_W+PL_W-1:0]  hl_ff;
   logic [PH_W+PL_W-1:0]  hl_in;
   logic [2*PL_W-1:0]     ll_ff;
   logic [2*PL_W-1:0]     ll_in;
   logic [SQ_W-1:0]       sq_ff;
   logic [SQ_W-1:0]       sq_in;
   logic [SQ_W-1:0]       lhs;
   logic                  hit_ff;
   logic                  hit_in;

   assign prod_in = P_W'(bound) * P_W'(x_mag);
   assign ph      = prod_ff[P_W-1:PL_W];
   assign pl      = prod_ff[PL_W-1:0];

   // p^2 = ph^2 << 2L + 2 ph pl << L + pl^2
   assign hh_in = (2*PH_W)'(ph) * (2*PH_W)'(ph);
   assign hl_in = (PH_W+PL_W)'(ph) * (PH_W+PL_W)'(pl);
   assign ll_in = (2*PL_W)'(pl) * (2*PL_W)'(pl);

   assign sq_in = {hh_ff, {(2*PL_W){1'b0}}}
                + SQ_W'({hl_ff, {(PL_W+1){1'b0}}})
                + SQ_W'(ll_ff);

   assign lhs    = SQ_W'({r2_late, {TAN_FRAC2{1'b0}}});
   assign hit_in = (lhs <= sq_ff);

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
      hh_ff   <= hh_in;
      hl_ff   <= hl_in;
      ll_ff   <= ll_in;
      sq_ff   <= sq_in;
      hit_ff  <= hit_in;
   end

   assign hit = hit_ff;

endmodule

// File: hw/rtl/lidar_point_sector_binner_top.sv
// lidar point sector binner: layer test lanes, atan2 cell chain, sector quantizer
// the result strobe follows the entry stage, the atan2 cell chain and the result register
// throughput: one item per cycle while not busy; 14-cell atan2 chain, 4-stage bound lanes
// reset: clears valids and restores register defaults; busy is high during reset,
// falls in the cycle after reset is released and is otherwise low
// the result port cannot be stalled: every accepted item gives one strobe
`timescale 1ns / 1ps
`include "lidar_point_sector_binner_top_assert.svh"

module lidar_point_sector_binner_top import lpsb_pkg::*; #(
   parameter int LAYERS = LAYERS_DEFAULT
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   output logic                          busy,
   input  logic signed [COORD_W-1:0]     req_point_x,
   input  logic signed [COORD_W-1:0]     req_point_y,
   input  logic signed [COORD_W-1:0]     req_point_z,
   input  logic [INTENSITY_W-1:0]        req_point_intensity,
   output logic                          rsp_valid,
   output logic [INDEX_W-1:0]            rsp_submap_index,
   output logic                          rsp_keep,
   input  logic                          csr_write_enable,
   input  logic [CSR_ADDR_W-1:0]         csr_index,
   input  logic [CSR_DATA_W-1:0]         csr_wdata
);

   localparam int TOP           = LAYERS - 1;
   localparam int CHAIN_STAGES  = 1 + CORDIC_STEPS;
   localparam int LAYER_STAGES  = 5;
   localparam int LAYER_DELAY   = CHAIN_STAGES - LAYER_STAGES;
   localparam int LATENCY       = CHAIN_STAGES + 1;
   localparam logic [LAYER_W-1:0] TOP_LAYER = LAYER_W'(TOP);
   localparam logic [INDEX_W-1:0] MAX_INDEX = lpsb_layer_base(TOP_LAYER)
      + INDEX_W'((1 << lpsb_sector_shift(TOP_LAYER)) - 1);

   // configuration
   logic [INTENSITY_W-1:0] intensity_low_ff;
   logic [INTENSITY_W-1:0] intensity_high_ff;
   logic [BOUND_W-1:0]     tan_bound_ff [BOUNDS_MAX];
   logic                   busy_ff;
   logic                   accept;

   always_ff @(posedge clock) begin
      if (reset) begin
         intensity_low_ff  <= INTENSITY_LOW_RESET;
         intensity_high_ff <= INTENSITY_HIGH_RESET;
         for (int k = 0; k < BOUNDS_MAX; k++) begin
            tan_bound_ff[k] <= BOUND_RESET[k];
         end
      end else if (csr_write_enable) begin
         unique case (csr_index)
            CSR_INTENSITY_LOW:  intensity_low_ff  <= csr_wdata[INTENSITY_W-1:0];
            CSR_INTENSITY_HIGH: intensity_high_ff <= csr_wdata[INTENSITY_W-1:0];
            CSR_TAN_FIRST:      tan_bound_ff[0]   <= csr_wdata;
            CSR_TAN_SECOND:     tan_bound_ff[1]   <= csr_wdata;
            CSR_TAN_THIRD:      tan_bound_ff[2]   <= csr_wdata;
            CSR_TAN_FOURTH:     tan_bound_ff[3]   <= csr_wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b1;
      end else begin
         busy_ff <= 1'b0;
      end
   end

   assign busy   = busy_ff;
   assign accept = start && !busy_ff;

   // entry stage: near-axis and keep flags, half-turn prerotation
   lpsb_tag_type         tag0_in;
   lpsb_tag_type         tag0_ff;
   lpsb_vec_type         vec0_in;
   lpsb_vec_type         vec0_ff;
   logic signed [CW-1:0] y_ext;
   logic signed [CW-1:0] z_ext;

   assign y_ext = {{(CW-COORD_W){req_point_y[COORD_W-1]}}, req_point_y};
   assign z_ext = {{(CW-COORD_W){req_point_z[COORD_W-1]}}, req_point_z};

   always_comb begin
      tag0_in.valid = accept;
      tag0_in.near  = (req_point_y > -NEAR_LIMIT) && (req_point_y < NEAR_LIMIT)
                   && (req_point_z > -NEAR_LIMIT) && (req_point_z < NEAR_LIMIT);
      tag0_in.keep  = (req_point_intensity < intensity_low_ff)
                   || (req_point_intensity > intensity_high_ff);
      if (z_ext[CW-1]) begin
         vec0_in.y   = -y_ext;
         vec0_in.z   = -z_ext;
         vec0_in.ang = y_ext[CW-1] ? -HALF_TURN : HALF_TURN;
      end else begin
         vec0_in.y   = y_ext;
         vec0_in.z   = z_ext;
         vec0_in.ang = '0;
      end
   end

   always_ff @(posedge clock) begin
      vec0_ff <= vec0_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tag0_ff <= '0;
      end else begin
         tag0_ff <= tag0_in;
      end
   end

   // atan2 cell chain
   lpsb_vec_type vec_chain [CORDIC_STEPS+1];
   lpsb_tag_type tag_chain [CORDIC_STEPS+1];

   assign vec_chain[0] = vec0_ff;
   assign tag_chain[0] = tag0_ff;

   for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_cell
      lpsb_cordic_cell #(
         .STEP (i)
      ) u_cell (
         .clock   (clock),
         .reset   (reset),
         .vec_in  (vec_chain[i]),
         .tag_in  (tag_chain[i]),
         .vec_out (vec_chain[i+1]),
         .tag_out (tag_chain[i+1])
      );
   end

   // radius squared, aligned with the bound lanes
   logic signed [R2_W-1:0] ysq_in;
   logic signed [R2_W-1:0] zsq_in;
   logic [R2_W-1:0]        ysq_ff;
   logic [R2_W-1:0]        zsq_ff;
   logic [R2_W-1:0]        r2_ff;
   logic [R2_W-1:0]        r2_late_ff;

   assign ysq_in = R2_W'(req_point_y) * R2_W'(req_point_y);
   assign zsq_in = R2_W'(req_point_z) * R2_W'(req_point_z);

   always_ff @(posedge clock) begin
      ysq_ff     <= ysq_in;
      zsq_ff     <= zsq_in;
      r2_ff      <= ysq_ff + zsq_ff;
      r2_late_ff <= r2_ff;
   end

   // bound lanes
   logic [TOP-1:0] hit;

   for (genvar k = 0; k < TOP; k++) begin : g_bound
      lpsb_bound_cell u_bound (
         .clock   (clock),
         .x_mag   (req_point_x[XMAG_W-1:0]),
         .bound   (tan_bound_ff[k]),
         .r2_late (r2_late_ff),
         .hit     (hit[k])
      );
   end

   lpsb_xflag_type xflag_in;
   lpsb_xflag_type xflag_ff [LAYER_STAGES-1];

   assign xflag_in.neg  = req_point_x[COORD_W-1];
   assign xflag_in.zero = (req_point_x == '0);

   always_ff @(posedge clock) begin
      xflag_ff[0] <= xflag_in;
      for (int s = 1; s < LAYER_STAGES - 1; s++) begin
         xflag_ff[s] <= xflag_ff[s-1];
      end
   end

   // layer select and delay to the chain end
   logic [LAYER_W-1:0] layer_in;
   logic [LAYER_W-1:0] layer_ff;
   logic [LAYER_W-1:0] layer_dly_ff [LAYER_DELAY];
   logic [LAYER_W-1:0] layer_end;

   always_comb begin
      layer_in = TOP_LAYER;
      priority if (xflag_ff[LAYER_STAGES-2].neg) begin
         layer_in = '0;
      end else if (xflag_ff[LAYER_STAGES-2].zero) begin
         layer_in = TOP_LAYER;
      end else begin
         for (int k = TOP - 1; k >= 0; k--) begin
            if (hit[k]) begin
               layer_in = LAYER_W'(k);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      layer_ff        <= layer_in;
      layer_dly_ff[0] <= layer_ff;
      for (int s = 1; s < LAYER_DELAY; s++) begin
         layer_dly_ff[s] <= layer_dly_ff[s-1];
      end
   end

   assign layer_end = layer_dly_ff[LAYER_DELAY-1];

   // sector quantizer and result register
   lpsb_vec_type          vec_end;
   lpsb_tag_type          tag_end;
   logic signed [ANG_W:0] u_sum;
   logic [U_W-1:0]        u_clamp;
   logic [2:0]            s_shift;
   logic [TMP_W-1:0]      sect_tmp;
   logic [SECT_W-1:0]     sect_raw;
   logic [SECT_W-1:0]     sect_n;
   logic [SECT_W-1:0]     sector;
   logic [INDEX_W-1:0]    index_in;
   logic                  rsp_valid_ff;
   logic [INDEX_W-1:0]    rsp_index_ff;
   logic                  rsp_keep_ff;

   assign vec_end = vec_chain[CORDIC_STEPS];
   assign tag_end = tag_chain[CORDIC_STEPS];

   always_comb begin
      u_sum = (ANG_W+1)'(vec_end.ang) + (ANG_W+1)'(HALF_TURN);
      priority if (u_sum[ANG_W]) begin
         u_clamp = '0;
      end else if (u_sum > (ANG_W+1)'(U_FULL)) begin
         u_clamp = U_FULL;
      end else begin
         u_clamp = u_sum[U_W-1:0];
      end
      s_shift  = lpsb_sector_shift(layer_end);
      sect_tmp = (TMP_W'(u_clamp) << s_shift) + SECT_ROUND;
      sect_raw = sect_tmp[TMP_W-1:16];
      sect_n   = SECT_W'(1) << s_shift;
      priority if (sect_raw == '0) begin
         sector = SECT_W'(1);
      end else if (sect_raw > sect_n) begin
         sector = sect_n;
      end else begin
         sector = sect_raw;
      end
      if (tag_end.near) begin
         index_in = '0;
      end else begin
         index_in = lpsb_layer_base(layer_end) + sector[INDEX_W-1:0] - INDEX_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      rsp_index_ff <= index_in;
      rsp_keep_ff  <= tag_end.keep;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= tag_end.valid;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_submap_index = rsp_index_ff;
   assign rsp_keep         = rsp_keep_ff;

   `LPSB_ASSERT_IMP(a_index_range, clock, reset, rsp_valid, rsp_submap_index <= MAX_INDEX, "submap index out of range")
   `LPSB_ASSERT_DLY(a_latency, clock, reset, accept, LATENCY, rsp_valid, "accepted item gave no result")
   `LPSB_ASSERT_NXT(a_near_zero, clock, reset, tag_end.valid && tag_end.near, rsp_submap_index == '0, "near-axis item not in submap zero")

endmodule

// File: tb/lidar_point_sector_binner_top_tb.sv
// self-checking testbench for the lidar point sector binner: directed and random points
`timescale 1ns / 1ps

module lidar_point_sector_binner_top_tb import lpsb_pkg::*; ();

   localparam int BIN_LAYERS     = 5;
   localparam int TOP_LAYER      = BIN_LAYERS - 1;
   localparam int PIPE_LATENCY   = 16;
   localparam int WATCHDOG_LIMIT = 2000;
   localparam int MAX_GAP        = 8;
   localparam int RANDOM_PHASES  = 4;
   localparam int PHASE_POINTS   = 200;

   localparam logic [CSR_ADDR_W-1:0] CSR_SPARE_LOW  = 3'd6;
   localparam logic [CSR_ADDR_W-1:0] CSR_SPARE_HIGH = 3'd7;

   typedef struct packed {
      logic signed [COORD_W-1:0] x;
      logic signed [COORD_W-1:0] y;
      logic signed [COORD_W-1:0] z;
      logic [INTENSITY_W-1:0]    intensity;
   } lidar_point_type;

   typedef struct packed {
      lidar_point_type     pt;
      logic [INDEX_W-1:0]  submap;
      logic                keep;
   } binned_point_type;

   typedef struct packed {
      logic [INTENSITY_W-1:0]          low;
      logic [INTENSITY_W-1:0]          high;
      logic [3:0][BOUND_W-1:0]         bound;
   } binner_cfg_type;

   logic clock = 1'b0;
   logic reset;
   logic start;
   logic busy;
   logic signed [COORD_W-1:0] req_point_x;
   logic signed [COORD_W-1:0] req_point_y;
   logic signed [COORD_W-1:0] req_point_z;
   logic [INTENSITY_W-1:0]    req_point_intensity;
   logic                      rsp_valid;
   logic [INDEX_W-1:0]        rsp_submap_index;
   logic                      rsp_keep;
   logic                      csr_write_enable;
   logic [CSR_ADDR_W-1:0]     csr_index;
   logic [CSR_DATA_W-1:0]     csr_wdata;

   logic [INTENSITY_W-1:0] cfg_low;
   logic [INTENSITY_W-1:0] cfg_high;
   logic [BOUND_W-1:0]     cfg_bound [4];

   binned_point_type pending_bins[$];
   int mismatches = 0;
   int idle_cycles = 0;
   int sender_idle_pct = 0;

   lidar_point_sector_binner_top #(
      .LAYERS(BIN_LAYERS)
   ) i_dut (
      .clock               (clock),
      .reset               (reset),
      .start               (start),
      .busy                (busy),
      .req_point_x         (req_point_x),
      .req_point_y         (req_point_y),
      .req_point_z         (req_point_z),
      .req_point_intensity (req_point_intensity),
      .rsp_valid           (rsp_valid),
      .rsp_submap_index    (rsp_submap_index),
      .rsp_keep            (rsp_keep),
      .csr_write_enable    (csr_write_enable),
      .csr_index           (csr_index),
      .csr_wdata           (csr_wdata)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   function automatic int atan_step(input int i);
      case (i)
         0:  return 8192;
         1:  return 4836;
         2:  return 2555;
         3:  return 1297;
         4:  return 651;
         5:  return 326;
         6:  return 163;
         7:  return 81;
         8:  return 41;
         9:  return 20;
         10: return 10;
         11: return 5;
         12: return 3;
         default: return 1;
      endcase
   endfunction

   // atan2(y, z) in binary angle units, 14 vectoring steps
   function automatic int bau_angle(input longint y, input longint z);
      int ang;
      longint dz;
      longint dy;
      ang = 0;
      if (z < 0) begin
         ang = (y >= 0) ? 32768 : -32768;
         z = -z;
         y = -y;
      end
      for (int i = 0; i < 14; i++) begin
         dz = y >>> i;
         dy = z >>> i;
         if (y >= 0) begin
            z = z + dz;
            y = y - dy;
            ang = ang + atan_step(i);
         end else begin
            z = z - dz;
            y = y + dy;
            ang = ang - atan_step(i);
         end
      end
      return ang;
   endfunction

   function automatic binned_point_type predict_bin(input lidar_point_type p);
      binned_point_type r;
      longint x;
      longint y;
      longint z;
      longint r2;
      longint prod;
      longint u;
      longint n;
      longint base;
      longint sector;
      logic [127:0] lhs;
      logic [127:0] rhs;
      int layer;
      bit found;
      x = p.x;
      y = p.y;
      z = p.z;
      r.pt = p;
      r.keep = (p.intensity < cfg_low) || (p.intensity > cfg_high);
      if (y > -100 && y < 100 && z > -100 && z < 100) begin
         r.submap = '0;
      end else begin
         r2 = y * y + z * z;
         lhs = r2;
         lhs = lhs << 28;
         layer = TOP_LAYER;
         found = 1'b0;
         if (x < 0) begin
            layer = 0;
         end else if (x > 0) begin
            for (int k = 0; k < TOP_LAYER; k++) begin
               prod = longint'(cfg_bound[k]) * x;
               rhs = prod;
               rhs = rhs * rhs;
               if (!found && lhs <= rhs) begin
                  layer = k;
                  found = 1'b1;
               end
            end
         end
         u = longint'(bau_angle(y, z)) + 32768;
         if (u < 0) u = 0;
         if (u > 65536) u = 65536;
         case (layer)
            0:       begin n = 1;  base = 0;  end
            1:       begin n = 4;  base = 1;  end
            2:       begin n = 8;  base = 5;  end
            3:       begin n = 16; base = 13; end
            default: begin n = 32; base = 29; end
         endcase
         sector = (u * n + 65535) >>> 16;
         if (sector < 1) sector = 1;
         if (sector > n) sector = n;
         r.submap = INDEX_W'(base + sector - 1);
      end
      return r;
   endfunction

   task automatic report_mismatch(input string msg);
      $display("%0t ns mismatch: %s", $time, msg);
      mismatches++;
   endtask

   // register mirror, prediction, result check and watchdog
   always @(posedge clock) begin
      binned_point_type want;
      if (!reset) begin
         if (csr_write_enable) begin
            case (csr_index)
               CSR_INTENSITY_LOW:  cfg_low = csr_wdata[INTENSITY_W-1:0];
               CSR_INTENSITY_HIGH: cfg_high = csr_wdata[INTENSITY_W-1:0];
               CSR_TAN_FIRST:      cfg_bound[0] = csr_wdata;
               CSR_TAN_SECOND:     cfg_bound[1] = csr_wdata;
               CSR_TAN_THIRD:      cfg_bound[2] = csr_wdata;
               CSR_TAN_FOURTH:     cfg_bound[3] = csr_wdata;
               default: ;
            endcase
         end
         if (rsp_valid) begin
            if (pending_bins.size() == 0) begin
               report_mismatch($sformatf("result submap %0d keep %0b with no item pending",
                  rsp_submap_index, rsp_keep));
            end else begin
               want = pending_bins.pop_front();
               if (rsp_submap_index !== want.submap)
                  report_mismatch($sformatf("point (%0d,%0d,%0d) submap %0d, want %0d",
                     want.pt.x, want.pt.y, want.pt.z, rsp_submap_index, want.submap));
               if (rsp_keep !== want.keep)
                  report_mismatch($sformatf("point (%0d,%0d,%0d) i=%0d keep %0b, want %0b",
                     want.pt.x, want.pt.y, want.pt.z, want.pt.intensity, rsp_keep,
                     want.keep));
            end
         end
         if (start && !busy)
            pending_bins.insert(pending_bins.size(), predict_bin({req_point_x, req_point_y,
               req_point_z, req_point_intensity}));
         if ((start && !busy) || rsp_valid) begin
            idle_cycles = 0;
         end else begin
            idle_cycles++;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
               $display("watchdog: no item or result for %0d cycles", idle_cycles);
               $display("Simulation FAILED");
               $finish;
            end
         end
      end
   end

   task automatic send_point(input lidar_point_type p);
      int gap;
      gap = 0;
      @(negedge clock);
      while (gap < MAX_GAP && $urandom_range(0, 99) < sender_idle_pct) begin
         start <= 1'b0;
         gap++;
         @(negedge clock);
      end
      start               <= 1'b1;
      req_point_x         <= p.x;
      req_point_y         <= p.y;
      req_point_z         <= p.z;
      req_point_intensity <= p.intensity;
      do @(posedge clock); while (busy);
   endtask

   task automatic send_xyz(input int x, input int y, input int z, input int inten);
      lidar_point_type p;
      p.x = COORD_W'(x);
      p.y = COORD_W'(y);
      p.z = COORD_W'(z);
      p.intensity = INTENSITY_W'(inten);
      send_point(p);
   endtask

   task automatic wait_idle();
      @(negedge clock);
      start <= 1'b0;
      while (pending_bins.size() != 0) @(posedge clock);
   endtask

   task automatic write_reg(input logic [CSR_ADDR_W-1:0] idx, input logic [CSR_DATA_W-1:0] val);
      @(negedge clock);
      csr_write_enable <= 1'b1;
      csr_index        <= idx;
      csr_wdata        <= val;
      @(negedge clock);
      csr_write_enable <= 1'b0;
   endtask

   task automatic apply_config(input binner_cfg_type c);
      wait_idle();
      write_reg(CSR_INTENSITY_LOW, CSR_DATA_W'(c.low));
      write_reg(CSR_INTENSITY_HIGH, CSR_DATA_W'(c.high));
      write_reg(CSR_TAN_FIRST, c.bound[0]);
      write_reg(CSR_TAN_SECOND, c.bound[1]);
      write_reg(CSR_TAN_THIRD, c.bound[2]);
      write_reg(CSR_TAN_FOURTH, c.bound[3]);
   endtask

   // random width so that small and full-scale values both show up
   function automatic logic signed [COORD_W-1:0] random_coord();
      logic signed [COORD_W-1:0] v;
      v = COORD_W'($urandom);
      return v >>> $urandom_range(0, COORD_W - 1);
   endfunction

   function automatic lidar_point_type random_point();
      lidar_point_type p;
      int mode;
      int x;
      int reach;
      mode = $urandom_range(0, 99);
      p.intensity = INTENSITY_W'($urandom);
      if (mode < 35) begin
         p.x = random_coord();
         p.y = random_coord();
         p.z = random_coord();
      end else if (mode < 85) begin
         // radial distance aimed across the ring layers
         x = $urandom_range(200, 500000);
         reach = int'((longint'(x) * $urandom_range(0, 20000)) / 16384) + 1;
         p.y = COORD_W'($urandom_range(0, 2 * reach) - reach);
         p.z = COORD_W'($urandom_range(0, 2 * reach) - reach);
         if ($urandom_range(0, 9) == 0) x = -x;
         if ($urandom_range(0, 29) == 0) x = 0;
         p.x = COORD_W'(x);
      end else begin
         p.x = random_coord();
         p.y = COORD_W'($urandom_range(0, 300) - 150);
         p.z = COORD_W'($urandom_range(0, 300) - 150);
      end
      return p;
   endfunction

   function automatic binner_cfg_type random_config();
      binner_cfg_type c;
      c.low  = INTENSITY_W'($urandom);
      c.high = INTENSITY_W'($urandom);
      if ($urandom_range(0, 2) == 0) begin
         for (int k = 0; k < 4; k++) c.bound[k] = BOUND_W'($urandom);
      end else begin
         c.bound[0] = BOUND_W'($urandom_range(0, 4000));
         for (int k = 1; k < 4; k++)
            c.bound[k] = c.bound[k-1] + BOUND_W'($urandom_range(0, 4000));
      end
      return c;
   endfunction

   function automatic binner_cfg_type default_config();
      binner_cfg_type c;
      c.low = 8'd120;
      c.high = 8'd175;
      c.bound[0] = 16'd2023;
      c.bound[1] = 16'd4109;
      c.bound[2] = 16'd6329;
      c.bound[3] = 16'd8769;
      return c;
   endfunction

   task automatic test_field_extremes();
      send_xyz(524287, 524287, 524287, 0);
      send_xyz(-524288, -524288, -524288, 255);
      send_xyz(524287, 0, -524288, 119);
      send_xyz(1, -524288, 0, 120);
      send_xyz(-524288, 524287, -524288, 175);
      send_xyz(0, -524288, 524287, 176);
   endtask

   task automatic test_near_axis();
      send_xyz(-524288, 99, -99, 200);
      send_xyz(0, -99, 99, 10);
      send_xyz(5000, 100, 0, 130);
      send_xyz(5000, 0, -100, 130);
   endtask

   task automatic test_x_sign();
      send_xyz(-1, 3000, 4000, 50);
      send_xyz(0, 3000, -4000, 50);
   endtask

   task automatic test_sector_wrap();
      send_xyz(1000, -1, -524288, 90);
      send_xyz(1000, 0, -524288, 90);
      send_xyz(1000, -1, -200, 90);
   endtask

   task automatic test_default_layers();
      send_xyz(100000, 8000, 0, 150);
      send_xyz(100000, 20000, 0, 150);
      send_xyz(100000, 0, -35000, 150);
      send_xyz(100000, -50000, 0, 150);
      send_xyz(100000, 42000, 42000, 150);
   endtask

   task automatic test_register_extremes();
      binner_cfg_type c;
      c.low = 8'd0;
      c.high = 8'd255;
      for (int k = 0; k < 4; k++) c.bound[k] = 16'd0;
      apply_config(c);
      for (int i = 0; i < 6; i++) send_point(random_point());
      send_xyz(524287, 200, 0, 0);
      send_xyz(524287, 200, 0, 255);
      c.low = 8'd255;
      c.high = 8'd0;
      for (int k = 0; k < 4; k++) c.bound[k] = 16'hffff;
      apply_config(c);
      for (int i = 0; i < 6; i++) send_point(random_point());
      send_xyz(1, 524287, 524287, 255);
   endtask

   task automatic test_spare_index();
      wait_idle();
      write_reg(CSR_SPARE_LOW, CSR_DATA_W'($urandom));
      write_reg(CSR_SPARE_HIGH, CSR_DATA_W'($urandom));
      for (int i = 0; i < 6; i++) send_point(random_point());
   endtask

   task automatic test_random_stream();
      for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
         apply_config(ph == 0 ? default_config() : random_config());
         case (ph)
            0:       sender_idle_pct = 0;
            1:       sender_idle_pct = 60;
            2:       sender_idle_pct = 0;
            default: sender_idle_pct = 30;
         endcase
         for (int i = 0; i < PHASE_POINTS; i++) send_point(random_point());
      end
      sender_idle_pct = 0;
   endtask

   initial begin
      reset               = 1'b1;
      start               = 1'b0;
      req_point_x         = '0;
      req_point_y         = '0;
      req_point_z         = '0;
      req_point_intensity = '0;
      csr_write_enable    = 1'b0;
      csr_index           = '0;
      csr_wdata           = '0;
      cfg_low             = 8'd120;
      cfg_high            = 8'd175;
      cfg_bound[0]        = 16'd2023;
      cfg_bound[1]        = 16'd4109;
      cfg_bound[2]        = 16'd6329;
      cfg_bound[3]        = 16'd8769;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_field_extremes();
      test_near_axis();
      test_x_sign();
      test_sector_wrap();
      test_default_layers();
      test_register_extremes();
      test_spare_index();
      test_random_stream();

      wait_idle();
      repeat (PIPE_LATENCY + 4) @(posedge clock);
      if (mismatches == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule

// File: sim.f
+incdir+hw/rtl
hw/rtl/lpsb_pkg.sv
hw/rtl/lpsb_cordic_cell.sv
hw/rtl/lpsb_bound_cell.sv
hw/rtl/lidar_point_sector_binner_top.sv
tb/lidar_point_sector_binner_top_tb.sv
